[sv/bhrc_pkg.sv]
// ----------------------------------------------------------------------------
// bhrc_pkg
// Shared types and constants for the reset button hold-time classifier.
// ----------------------------------------------------------------------------
package bhrc_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int HOLD_W          = 24;
    localparam int APB_ADDR_W      = 5;
    localparam int APB_DATA_W      = 32;
    localparam int REG_IDX_W       = 3;

    // register indexes, byte address = 4 * index
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_HOLD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_HOLD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PWR_ONLY = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INV_PIN  = 3'd4;

    localparam logic [HOLD_W-1:0] DEBOUNCE_RST = 24'd5;
    localparam logic [HOLD_W-1:0] MIN_HOLD_RST = 24'd5000;
    localparam logic [HOLD_W-1:0] MAX_HOLD_RST = 24'd10000;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_IDLE  = 3'd1,
        PH_SOFT  = 3'd2,
        PH_FACT  = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REQ_NONE = 2'd0,
        REQ_SOFT = 2'd1,
        REQ_FACT = 2'd2
    } t_req;

    typedef struct packed {
        logic [HOLD_W-1:0] debounce_ticks;
        logic [HOLD_W-1:0] min_hold_ticks;
        logic [HOLD_W-1:0] max_hold_ticks;
        logic              power_on_only;
        logic              invert_pin;
    } t_cfg;

endpackage

[sv/bhrc_cfg.sv]
// ----------------------------------------------------------------------------
// bhrc_cfg
// APB register file holding the hold thresholds and pin options.
// ----------------------------------------------------------------------------
module bhrc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bhrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bhrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bhrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output bhrc_pkg::t_cfg                    o_cfg
);
    import bhrc_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
            r_cfg.min_hold_ticks <= MIN_HOLD_RST;
            r_cfg.max_hold_ticks <= MAX_HOLD_RST;
            r_cfg.power_on_only  <= 1'b0;
            r_cfg.invert_pin     <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= pwdata[HOLD_W-1:0];
                REG_MIN_HOLD: r_cfg.min_hold_ticks <= pwdata[HOLD_W-1:0];
                REG_MAX_HOLD: r_cfg.max_hold_ticks <= pwdata[HOLD_W-1:0];
                REG_PWR_ONLY: r_cfg.power_on_only  <= pwdata[0];
                REG_INV_PIN:  r_cfg.invert_pin     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_DEBOUNCE: prdata = APB_DATA_W'(r_cfg.debounce_ticks);
            REG_MIN_HOLD: prdata = APB_DATA_W'(r_cfg.min_hold_ticks);
            REG_MAX_HOLD: prdata = APB_DATA_W'(r_cfg.max_hold_ticks);
            REG_PWR_ONLY: prdata = APB_DATA_W'(r_cfg.power_on_only);
            REG_INV_PIN:  prdata = APB_DATA_W'(r_cfg.invert_pin);
            default:      prdata = '0;
        endcase
    end

endmodule

[sv/bhrc_core.sv]
// ----------------------------------------------------------------------------
// bhrc_core
// Hold-time state machine and saturating elapsed-tick counter.
// ----------------------------------------------------------------------------
module bhrc_core #(
    parameter int COUNT_WIDTH = bhrc_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_kind,
    input  logic             i_pin_level,
    input  bhrc_pkg::t_cfg   i_cfg,
    output bhrc_pkg::t_req   o_reset_request,
    output bhrc_pkg::t_phase o_phase
);
    import bhrc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > HOLD_W) ? COUNT_WIDTH : HOLD_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   is_event, pressed, release_ev;
    logic                   ge_debounce, ge_min, ge_max;
    t_req                   request;

    assign is_event   = i_kind;
    assign pressed    = i_pin_level ^ i_cfg.invert_pin;
    assign release_ev = is_event && !pressed;

    // tick counts only inside a window; the window cases pick this value
    assign cnt_inc = (!is_event && (r_elapsed != CNT_MAX)) ? r_elapsed + 1'b1 : r_elapsed;
    assign cnt_ext = CMP_W'(cnt_inc);

    assign ge_debounce = cnt_ext >= CMP_W'(i_cfg.debounce_ticks);
    assign ge_min      = cnt_ext >= CMP_W'(i_cfg.min_hold_ticks);
    assign ge_max      = cnt_ext >= CMP_W'(i_cfg.max_hold_ticks);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        case (r_phase)
            PH_FIRST: begin
                n_elapsed = '0;
                n_phase   = pressed ? PH_FACT : PH_IDLE;
            end
            PH_IDLE: begin
                if (is_event && pressed) begin
                    n_elapsed = '0;
                    n_phase   = PH_SOFT;
                end
            end
            PH_SOFT: begin
                n_elapsed = cnt_inc;
                if (ge_min) begin
                    n_phase = i_cfg.power_on_only ? PH_IDLE : PH_FACT;
                end else if (release_ev) begin
                    n_phase = ge_debounce ? PH_DONE : PH_IDLE;
                end
            end
            PH_FACT: begin
                n_elapsed = cnt_inc;
                if (ge_max) begin
                    n_phase = PH_IDLE;
                end else if (release_ev) begin
                    n_phase = ge_min ? PH_DONE : PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        request = REQ_NONE;
        case (r_phase)
            PH_SOFT: begin
                if (!ge_min && release_ev && ge_debounce) begin
                    request = REQ_SOFT;
                end
            end
            PH_FACT: begin
                if (!ge_max && release_ev && ge_min) begin
                    request = REQ_FACT;
                end
            end
            default: request = REQ_NONE;
        endcase
    end

    assign o_reset_request = request;
    assign o_phase         = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIRST;
            r_elapsed <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    a_req_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (request != REQ_NONE) |-> (n_phase == PH_DONE))
        else $error("request issued without entering done");

    a_req_from_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (request != REQ_NONE) |-> (r_phase == PH_SOFT || r_phase == PH_FACT))
        else $error("request outside a hold window");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("left done phase");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_phase == PH_SOFT || r_phase == PH_FACT))
        |=> (r_elapsed >= $past(r_elapsed)))
        else $error("elapsed counter went backward inside a window");

endmodule

[sv/button_hold_reset_classifier_top.sv]
// ----------------------------------------------------------------------------
// button_hold_reset_classifier_top
// Reset button hold-time classifier with an APB register port.
// ----------------------------------------------------------------------------
// An input beat reaches the result beat through two registers: the input register, then the result register.
// Throughput: one beat per cycle while i_out_stall stays low; the state machine step
//   is a single counter increment and three threshold compares between the two registers.
// Reset: synchronous, active low; phase returns to first sample, counter to zero,
//   registers to their defaults, both pipeline stages empty.
module button_hold_reset_classifier_top #(
    parameter int COUNT_WIDTH = bhrc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic                              i_pin_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_reset_request,
    output logic [2:0]                        o_phase,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bhrc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bhrc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bhrc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bhrc_pkg::*;

    t_cfg   cfg;
    t_req   core_req;
    t_phase core_phase;

    logic   r_in_valid, r_kind, r_pin_level;
    logic   r_out_valid;
    t_req   r_req;
    t_phase r_phase_out;
    logic   out_ready, fire, in_accept;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    bhrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bhrc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_kind          (r_kind),
        .i_pin_level     (r_pin_level),
        .i_cfg           (cfg),
        .o_reset_request (core_req),
        .o_phase         (core_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind      <= i_kind;
            r_pin_level <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_req       <= core_req;
            r_phase_out <= core_phase;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reset_request = r_req;
    assign o_phase         = r_phase_out;

endmodule

[test/button_hold_reset_classifier_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_hold_reset_classifier_top_tb
// Self-checking bench for the reset button hold-time classifier. A directed
// table walks the first sample, both windows, expiry and ignored items. Random
// press/hold/release sequences and noise then run under several register
// settings and handshake idling patterns. The run closes with one sequence
// that is let through to a reset request, followed by beats in the done phase.
// Every result beat is compared with an in-bench prediction of the phase
// machine, or with the table's expected values for typed directed rows.
// ----------------------------------------------------------------------------
module button_hold_reset_classifier_top_tb;

    import bhrc_pkg::*;

    localparam int CW = COUNT_WIDTH_DEF;
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};
    localparam int MAX_REPORTS = 100;

    localparam logic [REG_IDX_W-1:0] REG_LIST [0:4] = '{
        REG_DEBOUNCE, REG_MIN_HOLD, REG_MAX_HOLD, REG_PWR_ONLY, REG_INV_PIN
    };

    typedef struct packed {
        t_phase        ph;
        logic [CW-1:0] cnt;
    } hold_state_t;

    typedef struct packed {
        hold_state_t st;
        t_req        req;
    } hold_step_t;

    typedef struct packed {
        t_req   req;
        t_phase ph;
    } hold_result_t;

    typedef struct packed {
        logic   kind;
        logic   pin;
        bit     typed;
        t_req   req;
        t_phase ph;
    } dir_row_t;

    // Directed walk, thresholds debounce 2 / min 4 / max 6, pin not inverted.
    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{KIND_TICK,  1'b1, 1'b1, REQ_NONE, PH_FACT},   // held at power-up
        '{KIND_EVENT, 1'b1, 1'b0, REQ_NONE, PH_FIRST},  // press inside window
        '{KIND_TICK,  1'b0, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_EVENT, 1'b0, 1'b1, REQ_NONE, PH_IDLE},   // early release
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},  // tick in idle
        '{KIND_EVENT, 1'b0, 1'b0, REQ_NONE, PH_FIRST},  // release in idle
        '{KIND_EVENT, 1'b1, 1'b1, REQ_NONE, PH_SOFT},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_EVENT, 1'b0, 1'b0, REQ_NONE, PH_FIRST},  // below debounce
        '{KIND_EVENT, 1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b0, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},  // soft window expires
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b0, 1'b0, REQ_NONE, PH_FIRST},  // factory window expires
        '{KIND_EVENT, 1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST},
        '{KIND_TICK,  1'b1, 1'b0, REQ_NONE, PH_FIRST}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_kind = 1'b0;
    logic                  i_pin_level = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_reset_request;
    logic [2:0]            o_phase;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    t_cfg         hold_cfg;
    hold_state_t  hold_st;
    hold_result_t pending_results [$];
    hold_result_t exp_r;
    t_req         last_req = REQ_NONE;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_beats = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_settings = 0;

    button_hold_reset_classifier_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_pin_level     (i_pin_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reset_request (o_reset_request),
        .o_phase         (o_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Hold-time phase machine: next state and request for one item.
    // ------------------------------------------------------------------
    function automatic hold_step_t hold_next(hold_state_t s, t_cfg c, logic kind,
                                             logic pin);
        hold_step_t       n;
        logic             pressed;
        logic [HOLD_W-1:0] lim_expire;
        logic [HOLD_W-1:0] lim_release;
        n.st = s;
        n.req = REQ_NONE;
        pressed = pin ^ c.invert_pin;
        case (s.ph)
            PH_FIRST: begin
                n.st.cnt = '0;
                n.st.ph = pressed ? PH_FACT : PH_IDLE;
            end
            PH_IDLE: begin
                if (kind == KIND_EVENT && pressed) begin
                    n.st.cnt = '0;
                    n.st.ph = PH_SOFT;
                end
            end
            PH_SOFT, PH_FACT: begin
                if (kind == KIND_TICK && n.st.cnt != {CW{1'b1}})
                    n.st.cnt = n.st.cnt + 1'b1;
                lim_expire  = (s.ph == PH_SOFT) ? c.min_hold_ticks : c.max_hold_ticks;
                lim_release = (s.ph == PH_SOFT) ? c.debounce_ticks : c.min_hold_ticks;
                // expiry wins over a release on the same item
                if (n.st.cnt >= lim_expire) begin
                    if (s.ph == PH_SOFT && !c.power_on_only)
                        n.st.ph = PH_FACT;
                    else
                        n.st.ph = PH_IDLE;
                end else if (kind == KIND_EVENT && !pressed) begin
                    if (n.st.cnt >= lim_release) begin
                        n.req = (s.ph == PH_SOFT) ? REQ_SOFT : REQ_FACT;
                        n.st.ph = PH_DONE;
                    end else begin
                        n.st.ph = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_word(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_DEBOUNCE: return APB_DATA_W'(hold_cfg.debounce_ticks);
            REG_MIN_HOLD: return APB_DATA_W'(hold_cfg.min_hold_ticks);
            REG_MAX_HOLD: return APB_DATA_W'(hold_cfg.max_hold_ticks);
            REG_PWR_ONLY: return APB_DATA_W'(hold_cfg.power_on_only);
            REG_INV_PIN:  return APB_DATA_W'(hold_cfg.invert_pin);
            default:      return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_regs();
        logic [APB_DATA_W-1:0] rd;
        for (int i = 0; i < 5; i++) begin
            apb_xfer(1'b0, REG_LIST[i], '0, rd);
            if (rd !== reg_word(REG_LIST[i])) begin
                n_errors++;
                $display("%t register %0d readback: expected %0d, got %0d",
                         $time, REG_LIST[i], reg_word(REG_LIST[i]), rd);
            end
        end
    endtask

    // Let every outstanding result come back, then allow for the pipeline.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_hold_cfg(input logic [HOLD_W-1:0] deb, input logic [HOLD_W-1:0] minh,
                                input logic [HOLD_W-1:0] maxh, input logic poo,
                                input logic inv);
        logic [APB_DATA_W-1:0] rd;
        drain();
        apb_xfer(1'b1, REG_DEBOUNCE, APB_DATA_W'(deb), rd);
        apb_xfer(1'b1, REG_MIN_HOLD, APB_DATA_W'(minh), rd);
        apb_xfer(1'b1, REG_MAX_HOLD, APB_DATA_W'(maxh), rd);
        apb_xfer(1'b1, REG_PWR_ONLY, APB_DATA_W'(poo), rd);
        apb_xfer(1'b1, REG_INV_PIN, APB_DATA_W'(inv), rd);
        hold_cfg.debounce_ticks = deb;
        hold_cfg.min_hold_ticks = minh;
        hold_cfg.max_hold_ticks = maxh;
        hold_cfg.power_on_only  = poo;
        hold_cfg.invert_pin     = inv;
        n_settings++;
        check_regs();
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input beats; the prediction is made at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic kind, input logic pin, input bit typed,
                             input t_req treq, input t_phase tph);
        hold_step_t nx;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_pin_level <= pin;
        do @(posedge i_clk); while (o_in_stall);
        nx = hold_next(hold_st, hold_cfg, kind, pin);
        hold_st = nx.st;
        n_beats++;
        if (nx.req != REQ_NONE)
            last_req = nx.req;
        if (typed)
            pending_results.push_back(hold_result_t'{treq, tph});
        else
            pending_results.push_back(hold_result_t'{nx.req, nx.st.ph});
    endtask

    // A release that would end the run early is turned into a tick.
    task automatic gen_beat(input logic kind, input logic pressed, input bit allow_req);
        hold_step_t nx;
        logic       k;
        logic       pin;
        k = kind;
        pin = pressed ^ hold_cfg.invert_pin;
        if (!allow_req) begin
            nx = hold_next(hold_st, hold_cfg, k, pin);
            if (nx.req != REQ_NONE)
                k = KIND_TICK;
        end
        send_beat(k, pin, 1'b0, REQ_NONE, PH_FIRST);
    endtask

    task automatic press_hold_release(input bit allow_req);
        int lim;
        int hold;
        lim = (hold_cfg.max_hold_ticks < 30) ? int'(hold_cfg.max_hold_ticks) + 2 : 30;
        hold = $urandom_range(lim);
        gen_beat(KIND_EVENT, 1'b1, allow_req);
        repeat (hold) begin
            if ($urandom_range(9) == 0)
                gen_beat(KIND_EVENT, 1'b1, allow_req);
            else if ($urandom_range(9) == 0)
                gen_beat(KIND_TICK, 1'($urandom_range(1)), allow_req);
            else
                gen_beat(KIND_TICK, 1'b1, allow_req);
        end
        gen_beat(KIND_EVENT, 1'b0, allow_req);
    endtask

    task automatic run_random(input int count);
        int start;
        start = n_beats;
        while (n_beats - start < count) begin
            if ($urandom_range(3) != 0)
                press_hold_release(1'b0);
            else
                repeat ($urandom_range(1, 4))
                    gen_beat(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%t unexpected result beat: request %0d phase %0d",
                             $time, o_reset_request, o_phase);
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (o_reset_request !== exp_r.req) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%t reset_request: expected %0d, got %0d",
                                 $time, exp_r.req, o_reset_request);
                end
                if (o_phase !== exp_r.ph) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%t phase: expected %0d, got %0d",
                                 $time, exp_r.ph, o_phase);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int guard;
        hold_cfg = '{DEBOUNCE_RST, MIN_HOLD_RST, MAX_HOLD_RST, 1'b0, 1'b0};
        hold_st  = '{PH_FIRST, {CW{1'b0}}};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        set_idling(0);
        set_hold_cfg(24'd2, 24'd4, 24'd6, 1'b0, 1'b0);
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(DIR_TAB[i].kind, DIR_TAB[i].pin, DIR_TAB[i].typed,
                      DIR_TAB[i].req, DIR_TAB[i].ph);

        for (int p = 1; p <= 7; p++) begin
            case (p)
                1: set_hold_cfg(HOLD_W'($urandom_range(6)), HOLD_W'($urandom_range(14)),
                                HOLD_W'($urandom_range(28)), 1'b0, 1'b1);
                2: set_hold_cfg('0, '0, '0, 1'b0, 1'b0);
                3: set_hold_cfg(HOLD_MAX, HOLD_MAX, HOLD_MAX, 1'b1, 1'b1);
                4: set_hold_cfg(HOLD_W'($urandom_range(6)), HOLD_W'($urandom_range(14)),
                                HOLD_W'($urandom_range(28)), 1'b1, 1'b0);
                5: set_hold_cfg('0, HOLD_W'($urandom_range(14)), HOLD_MAX, 1'b0, 1'b1);
                6: set_hold_cfg(HOLD_W'($urandom_range(6)), HOLD_W'($urandom_range(14)),
                                HOLD_W'($urandom_range(28)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
                default: set_hold_cfg(HOLD_MAX, HOLD_W'($urandom_range(14)),
                                      HOLD_W'($urandom_range(28)), 1'b0, 1'b0);
            endcase
            set_idling(p % 4);
            run_random(80);
        end

        // closing setting: one sequence goes through to a request
        begin
            logic [HOLD_W-1:0] deb;
            logic [HOLD_W-1:0] minh;
            deb  = HOLD_W'($urandom_range(1, 4));
            minh = deb + HOLD_W'($urandom_range(2, 8));
            set_hold_cfg(deb, minh, minh + HOLD_W'($urandom_range(2, 10)), 1'b0,
                         1'($urandom_range(1)));
        end
        set_idling(3);
        guard = 0;
        while (hold_st.ph != PH_DONE && guard < 20) begin
            press_hold_release(1'b1);
            guard++;
        end
        // done phase ignores everything
        repeat (8) send_beat(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                             REQ_NONE, PH_FIRST);

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d beats under %0d register settings, checked %0d results",
                 n_beats, n_settings, n_checked);
        $display("Closing request code %0d, %0d mismatches", last_req, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
